// File: src/ucre_pkg.sv
package ucre_pkg;

  typedef enum logic [1:0] {
    OP_RESET   = 2'd0,
    OP_SETUP   = 2'd1,
    OP_XFER    = 2'd2,
    OP_CONNECT = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    ACT_STALL      = 4'd0,
    ACT_SET_ADDR   = 4'd1,
    ACT_DATA_IN    = 4'd2,
    ACT_DATA_OUT   = 4'd3,
    ACT_STATUS_IN  = 4'd4,
    ACT_STATUS_OUT = 4'd5,
    ACT_OPEN_EPS   = 4'd6,
    ACT_CLOSE_EPS  = 4'd7,
    ACT_FUNC_CFG   = 4'd8,
    ACT_FWD_CLASS  = 4'd9,
    ACT_CTRL_OUT   = 4'd10,
    ACT_EP_DONE    = 4'd11,
    ACT_RECOVER_RX = 4'd12,
    ACT_REOPEN_IN  = 4'd13,
    ACT_REQUEUE_RX = 4'd14,
    ACT_NOTIFY_CFG = 4'd15
  } action_t;

  typedef enum logic [1:0] {
    DEV_DEFAULT    = 2'd0,
    DEV_ADDRESSED  = 2'd1,
    DEV_CONFIGURED = 2'd2
  } dev_state_t;

  typedef enum logic [2:0] {
    STG_IDLE = 3'd0,
    STG_DIN  = 3'd1,
    STG_DOUT = 3'd2,
    STG_SIN  = 3'd3,
    STG_SOUT = 3'd4
  } stage_t;

  localparam logic [1:0] SRC_CTRL  = 2'd0;
  localparam logic [1:0] SRC_DESC  = 2'd1;
  localparam logic [1:0] SRC_CLASS = 2'd2;

  localparam logic [7:0] REQ_GET_STATUS    = 8'd0;
  localparam logic [7:0] REQ_CLEAR_FEATURE = 8'd1;
  localparam logic [7:0] REQ_SET_FEATURE   = 8'd3;
  localparam logic [7:0] REQ_SET_ADDRESS   = 8'd5;
  localparam logic [7:0] REQ_GET_DESC      = 8'd6;
  localparam logic [7:0] REQ_GET_CONFIG    = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIG    = 8'd9;
  localparam logic [7:0] REQ_GET_IFACE     = 8'd10;
  localparam logic [7:0] REQ_SET_IFACE     = 8'd11;

  localparam logic [1:0] TYPE_STANDARD = 2'd0;
  localparam logic [1:0] TYPE_CLASS    = 2'd1;

  localparam int MAX_RECS = 8;

  typedef struct packed {
    action_t     action;
    logic [7:0]  target_endpoint;
    logic        action_flag;
    logic [15:0] transfer_length;
    logic [1:0]  data_source;
    logic [15:0] payload;
    dev_state_t  device_state_out;
  } rec_t;

  typedef struct packed {
    logic [3:0]           cnt;
    rec_t [MAX_RECS-1:0]  recs;
  } batch_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  function automatic rec_t mk(action_t a, logic [7:0] ep, logic f, logic [15:0] len,
                              logic [1:0] src, logic [15:0] pay, dev_state_t ds);
    rec_t r;
    r.action           = a;
    r.target_endpoint  = ep;
    r.action_flag      = f;
    r.transfer_length  = len;
    r.data_source      = src;
    r.payload          = pay;
    r.device_state_out = ds;
    return r;
  endfunction

endpackage

// File: src/ucre_front.sv
module ucre_front #(
  parameter int CONTROL_BUFFER_BYTES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  input  logic                accept,
  input  logic [1:0]          opcode,
  input  logic [63:0]         setup_packet,
  input  logic [7:0]          endpoint,
  input  logic                transfer_error,
  input  logic [15:0]         transfer_bytes,
  input  logic [1:0]          link_speed,
  input  logic                function_ok,
  input  logic                endpoints_ok,
  input  logic [15:0]         descriptor_length,
  input  logic                submit_ok,
  output logic                has_recs,
  output ucre_pkg::batch_t    batch
);

  localparam logic [15:0] CBB = 16'(CONTROL_BUFFER_BYTES);

  logic [7:0]           bulk_out_endpoint;
  ucre_pkg::dev_state_t device_state, device_state_next;
  logic                 active_configuration, active_configuration_next;
  ucre_pkg::stage_t     control_stage, control_stage_next;
  logic [1:0]           bus_speed, bus_speed_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      bulk_out_endpoint    <= 8'd1;
      device_state         <= ucre_pkg::DEV_DEFAULT;
      active_configuration <= 1'b0;
      control_stage        <= ucre_pkg::STG_IDLE;
      bus_speed            <= 2'd0;
    end else begin
      if (cfg_we) bulk_out_endpoint <= cfg_wdata;
      if (accept) begin
        device_state         <= device_state_next;
        active_configuration <= active_configuration_next;
        control_stage        <= control_stage_next;
        bus_speed            <= bus_speed_next;
      end
    end
  end

  always_comb begin
    logic [7:0]  bm, req;
    logic [15:0] wv, wi, wl, len;
    logic [3:0]  n;
    ucre_pkg::dev_state_t ds;
    ucre_pkg::stage_t     stg;
    logic ac;
    logic is_ep0;
    ucre_pkg::rec_t [ucre_pkg::MAX_RECS-1:0] r;

    bm  = setup_packet[7:0];
    req = setup_packet[15:8];
    wv  = setup_packet[31:16];
    wi  = setup_packet[47:32];
    wl  = setup_packet[63:48];
    len = 16'd0;
    n   = 4'd0;
    ds  = device_state;
    stg = control_stage;
    ac  = active_configuration;
    is_ep0 = (endpoint == 8'h00) || (endpoint == 8'h80);
    r   = '0;
    bus_speed_next = bus_speed;

    unique case (ucre_pkg::opcode_t'(opcode))
      ucre_pkg::OP_RESET: begin
        ds = ucre_pkg::DEV_DEFAULT; ac = 1'b0; stg = ucre_pkg::STG_IDLE;
        r[0] = ucre_pkg::mk(ucre_pkg::ACT_CLOSE_EPS, 8'd0, 1'b0, 16'd0, 2'd0, 16'd0, ds);
        r[1] = ucre_pkg::mk(ucre_pkg::ACT_FUNC_CFG, 8'd0, 1'b0, 16'd0, 2'd0,
                            {14'd0, bus_speed}, ds);
        n = 4'd2;
      end
      ucre_pkg::OP_SETUP: begin
        stg = ucre_pkg::STG_IDLE;
        if (bm[6:5] == ucre_pkg::TYPE_STANDARD) begin
          unique case (req)
            ucre_pkg::REQ_GET_STATUS: begin
              if (bm[4:0] > 5'd2) begin
                r[0] = ucre_pkg::mk(ucre_pkg::ACT_STALL, 8'd0, 1'b1, 16'd0, 2'd0, 16'd0, ds);
                n = 4'd1;
              end else begin
                stg = ucre_pkg::STG_DIN;
                r[0] = ucre_pkg::mk(ucre_pkg::ACT_DATA_IN, 8'd0, 1'b0, 16'd2,
                                    ucre_pkg::SRC_CTRL, 16'd0, ds);
                n = 4'd1;
              end
            end
            ucre_pkg::REQ_CLEAR_FEATURE, ucre_pkg::REQ_SET_FEATURE: begin
              if (bm != 8'h02 || wv != 16'd0) begin
                r[0] = ucre_pkg::mk(ucre_pkg::ACT_STALL, 8'd0, 1'b1, 16'd0, 2'd0, 16'd0, ds);
                n = 4'd1;
              end else begin
                r[0] = ucre_pkg::mk(ucre_pkg::ACT_STALL, wi[7:0],
                                    req == ucre_pkg::REQ_SET_FEATURE, 16'd0, 2'd0, 16'd0, ds);
                stg = ucre_pkg::STG_SIN;
                r[1] = ucre_pkg::mk(ucre_pkg::ACT_STATUS_IN, 8'd0, 1'b0, 16'd0, 2'd0,
                                    16'd0, ds);
                n = 4'd2;
              end
            end
            ucre_pkg::REQ_SET_ADDRESS: begin
              if (bm != 8'h00 || wv > 16'd127 || wi != 16'd0 || wl != 16'd0) begin
                r[0] = ucre_pkg::mk(ucre_pkg::ACT_STALL, 8'd0, 1'b1, 16'd0, 2'd0, 16'd0, ds);
                n = 4'd1;
              end else begin
                ds = ucre_pkg::DEV_ADDRESSED;
                r[0] = ucre_pkg::mk(ucre_pkg::ACT_SET_ADDR, 8'd0, 1'b0, 16'd0, 2'd0, wv, ds);
                stg = ucre_pkg::STG_SIN;
                r[1] = ucre_pkg::mk(ucre_pkg::ACT_STATUS_IN, 8'd0, 1'b0, 16'd0, 2'd0,
                                    16'd0, ds);
                n = 4'd2;
              end
            end
            ucre_pkg::REQ_GET_DESC: begin
              if (descriptor_length == 16'd0) begin
                r[0] = ucre_pkg::mk(ucre_pkg::ACT_STALL, 8'd0, 1'b1, 16'd0, 2'd0, 16'd0, ds);
                n = 4'd1;
              end else begin
                len = (descriptor_length > wl) ? wl : descriptor_length;
                stg = ucre_pkg::STG_DIN;
                r[0] = ucre_pkg::mk(ucre_pkg::ACT_DATA_IN, 8'd0, 1'b0, len,
                                    ucre_pkg::SRC_DESC, 16'd0, ds);
                n = 4'd1;
              end
            end
            ucre_pkg::REQ_SET_CONFIG: begin
              if (bm != 8'h00 || wv > 16'd1 || wi != 16'd0 || wl != 16'd0) begin
                r[0] = ucre_pkg::mk(ucre_pkg::ACT_STALL, 8'd0, 1'b1, 16'd0, 2'd0, 16'd0, ds);
                n = 4'd1;
              end else if (wv[0]) begin
                // reconfigure: tear down the running configuration first
                if (ds == ucre_pkg::DEV_CONFIGURED) begin
                  r[0] = ucre_pkg::mk(ucre_pkg::ACT_CLOSE_EPS, 8'd0, 1'b0, 16'd0, 2'd0,
                                      16'd0, ds);
                  r[1] = ucre_pkg::mk(ucre_pkg::ACT_FUNC_CFG, 8'd0, 1'b0, 16'd0, 2'd0,
                                      {14'd0, bus_speed}, ds);
                  ds = ucre_pkg::DEV_ADDRESSED;
                  n = 4'd2;
                end
                ac = 1'b1;
                r[n[2:0]] = ucre_pkg::mk(ucre_pkg::ACT_FUNC_CFG, 8'd0, 1'b1, 16'd0, 2'd0,
                                         {14'd0, bus_speed}, ds);
                n = n + 4'd1;
                if (!function_ok) begin
                  ac = 1'b0; ds = ucre_pkg::DEV_ADDRESSED;
                  r[n[2:0]] = ucre_pkg::mk(ucre_pkg::ACT_STALL, 8'd0, 1'b1, 16'd0, 2'd0,
                                           16'd0, ds);
                  n = n + 4'd1;
                end else begin
                  r[n[2:0]] = ucre_pkg::mk(ucre_pkg::ACT_OPEN_EPS, 8'd0, 1'b0, 16'd0, 2'd0,
                                           16'd0, ds);
                  n = n + 4'd1;
                  if (!endpoints_ok) begin
                    ac = 1'b0; ds = ucre_pkg::DEV_ADDRESSED;
                    r[n[2:0]] = ucre_pkg::mk(ucre_pkg::ACT_FUNC_CFG, 8'd0, 1'b0, 16'd0, 2'd0,
                                             {14'd0, bus_speed}, ds);
                    r[3'(n + 4'd1)] = ucre_pkg::mk(ucre_pkg::ACT_STALL, 8'd0, 1'b1, 16'd0,
                                                   2'd0, 16'd0, ds);
                    n = n + 4'd2;
                  end else begin
                    ds = ucre_pkg::DEV_CONFIGURED;
                    r[n[2:0]] = ucre_pkg::mk(ucre_pkg::ACT_NOTIFY_CFG, 8'd0, 1'b0, 16'd0,
                                             2'd0, 16'd0, ds);
                    stg = ucre_pkg::STG_SIN;
                    r[3'(n + 4'd1)] = ucre_pkg::mk(ucre_pkg::ACT_STATUS_IN, 8'd0, 1'b0,
                                                   16'd0, 2'd0, 16'd0, ds);
                    n = n + 4'd2;
                  end
                end
              end else begin
                ac = 1'b0; ds = ucre_pkg::DEV_ADDRESSED;
                r[0] = ucre_pkg::mk(ucre_pkg::ACT_CLOSE_EPS, 8'd0, 1'b0, 16'd0, 2'd0,
                                    16'd0, ds);
                r[1] = ucre_pkg::mk(ucre_pkg::ACT_FUNC_CFG, 8'd0, 1'b0, 16'd0, 2'd0,
                                    {14'd0, bus_speed}, ds);
                stg = ucre_pkg::STG_SIN;
                r[2] = ucre_pkg::mk(ucre_pkg::ACT_STATUS_IN, 8'd0, 1'b0, 16'd0, 2'd0,
                                    16'd0, ds);
                n = 4'd3;
              end
            end
            ucre_pkg::REQ_GET_CONFIG, ucre_pkg::REQ_GET_IFACE: begin
              stg = ucre_pkg::STG_DIN;
              r[0] = ucre_pkg::mk(ucre_pkg::ACT_DATA_IN, 8'd0, 1'b0, 16'd1,
                                  ucre_pkg::SRC_CTRL,
                                  (req == ucre_pkg::REQ_GET_CONFIG) ? {15'd0, ac} : 16'd0,
                                  ds);
              n = 4'd1;
            end
            ucre_pkg::REQ_SET_IFACE: begin
              if (wv == 16'd0) begin
                stg = ucre_pkg::STG_SIN;
                r[0] = ucre_pkg::mk(ucre_pkg::ACT_STATUS_IN, 8'd0, 1'b0, 16'd0, 2'd0,
                                    16'd0, ds);
              end else begin
                r[0] = ucre_pkg::mk(ucre_pkg::ACT_STALL, 8'd0, 1'b1, 16'd0, 2'd0, 16'd0, ds);
              end
              n = 4'd1;
            end
            default: begin
              r[0] = ucre_pkg::mk(ucre_pkg::ACT_STALL, 8'd0, 1'b1, 16'd0, 2'd0, 16'd0, ds);
              n = 4'd1;
            end
          endcase
          // data in / status in submissions above were each the last record
          if (!submit_ok && n != 4'd0 &&
              (r[3'(n - 4'd1)].action == ucre_pkg::ACT_DATA_IN ||
               r[3'(n - 4'd1)].action == ucre_pkg::ACT_STATUS_IN)) begin
            stg = ucre_pkg::STG_IDLE;
            r[n[2:0]] = ucre_pkg::mk(ucre_pkg::ACT_STALL, 8'd0, 1'b1, 16'd0, 2'd0, 16'd0, ds);
            n = n + 4'd1;
          end
        end else if (bm[6:5] == ucre_pkg::TYPE_CLASS) begin
          len = (wl > CBB) ? CBB : wl;
          r[0] = ucre_pkg::mk(ucre_pkg::ACT_FWD_CLASS, 8'd0, 1'b0, len,
                              ucre_pkg::SRC_CLASS, 16'd0, ds);
          if (!function_ok) begin
            r[1] = ucre_pkg::mk(ucre_pkg::ACT_STALL, 8'd0, 1'b1, 16'd0, 2'd0, 16'd0, ds);
            n = 4'd2;
          end else begin
            if (bm[7]) begin
              stg = ucre_pkg::STG_DIN;
              r[1] = ucre_pkg::mk(ucre_pkg::ACT_DATA_IN, 8'd0, 1'b0, len,
                                  ucre_pkg::SRC_CLASS, 16'd0, ds);
            end else if (len != 16'd0) begin
              stg = ucre_pkg::STG_DOUT;
              r[1] = ucre_pkg::mk(ucre_pkg::ACT_DATA_OUT, 8'd0, 1'b0, len,
                                  ucre_pkg::SRC_CLASS, 16'd0, ds);
            end else begin
              stg = ucre_pkg::STG_SIN;
              r[1] = ucre_pkg::mk(ucre_pkg::ACT_STATUS_IN, 8'd0, 1'b0, 16'd0, 2'd0,
                                  16'd0, ds);
            end
            n = 4'd2;
            if (!submit_ok) begin
              stg = ucre_pkg::STG_IDLE;
              r[2] = ucre_pkg::mk(ucre_pkg::ACT_STALL, 8'd0, 1'b1, 16'd0, 2'd0, 16'd0, ds);
              n = 4'd3;
            end
          end
        end else begin
          r[0] = ucre_pkg::mk(ucre_pkg::ACT_STALL, 8'd0, 1'b1, 16'd0, 2'd0, 16'd0, ds);
          n = 4'd1;
        end
      end
      ucre_pkg::OP_XFER: begin
        if (is_ep0) begin
          case (control_stage)
            ucre_pkg::STG_DIN: begin
              if (transfer_error) begin
                stg = ucre_pkg::STG_IDLE;
                r[0] = ucre_pkg::mk(ucre_pkg::ACT_STALL, 8'd0, 1'b1, 16'd0, 2'd0, 16'd0, ds);
                n = 4'd1;
              end else begin
                stg = ucre_pkg::STG_SOUT;
                r[0] = ucre_pkg::mk(ucre_pkg::ACT_STATUS_OUT, 8'd0, 1'b0, 16'd0, 2'd0,
                                    16'd0, ds);
                n = 4'd1;
                if (!submit_ok) begin
                  stg = ucre_pkg::STG_IDLE;
                  r[1] = ucre_pkg::mk(ucre_pkg::ACT_STALL, 8'd0, 1'b1, 16'd0, 2'd0,
                                      16'd0, ds);
                  n = 4'd2;
                end
              end
            end
            ucre_pkg::STG_DOUT: begin
              if (transfer_error || transfer_bytes == 16'd0) begin
                stg = ucre_pkg::STG_IDLE;
                r[0] = ucre_pkg::mk(ucre_pkg::ACT_STALL, 8'd0, 1'b1, 16'd0, 2'd0, 16'd0, ds);
                n = 4'd1;
              end else begin
                r[0] = ucre_pkg::mk(ucre_pkg::ACT_CTRL_OUT, 8'd0, 1'b0, transfer_bytes,
                                    2'd0, 16'd0, ds);
                if (!function_ok) begin
                  stg = ucre_pkg::STG_IDLE;
                  r[1] = ucre_pkg::mk(ucre_pkg::ACT_STALL, 8'd0, 1'b1, 16'd0, 2'd0,
                                      16'd0, ds);
                  n = 4'd2;
                end else begin
                  stg = ucre_pkg::STG_SIN;
                  r[1] = ucre_pkg::mk(ucre_pkg::ACT_STATUS_IN, 8'd0, 1'b0, 16'd0, 2'd0,
                                      16'd0, ds);
                  n = 4'd2;
                  if (!submit_ok) begin
                    stg = ucre_pkg::STG_IDLE;
                    r[2] = ucre_pkg::mk(ucre_pkg::ACT_STALL, 8'd0, 1'b1, 16'd0, 2'd0,
                                        16'd0, ds);
                    n = 4'd3;
                  end
                end
              end
            end
            ucre_pkg::STG_SIN, ucre_pkg::STG_SOUT: begin
              stg = ucre_pkg::STG_IDLE;
              if (transfer_error) begin
                r[0] = ucre_pkg::mk(ucre_pkg::ACT_STALL, 8'd0, 1'b1, 16'd0, 2'd0, 16'd0, ds);
                n = 4'd1;
              end
            end
            default: ;
          endcase
        end else begin
          r[0] = ucre_pkg::mk(ucre_pkg::ACT_EP_DONE, endpoint, transfer_error,
                              transfer_bytes, 2'd0, 16'd0, ds);
          n = 4'd1;
          if (transfer_error) begin
            r[1] = ucre_pkg::mk(endpoint[7] ? ucre_pkg::ACT_REOPEN_IN
                                            : ucre_pkg::ACT_RECOVER_RX,
                                endpoint, 1'b0, 16'd0, 2'd0, 16'd0, ds);
            n = 4'd2;
          end else if (endpoint == bulk_out_endpoint &&
                       ds == ucre_pkg::DEV_CONFIGURED) begin
            r[1] = ucre_pkg::mk(ucre_pkg::ACT_REQUEUE_RX, endpoint, 1'b0, 16'd0, 2'd0,
                                16'd0, ds);
            n = 4'd2;
            if (!submit_ok) begin
              r[2] = ucre_pkg::mk(ucre_pkg::ACT_RECOVER_RX, endpoint, 1'b0, 16'd0, 2'd0,
                                  16'd0, ds);
              n = 4'd3;
            end
          end
        end
      end
      default: bus_speed_next = link_speed;
    endcase

    device_state_next         = ds;
    active_configuration_next = ac;
    control_stage_next        = stg;
    batch.cnt  = n;
    batch.recs = r;
    has_recs   = (n != 4'd0);
  end

endmodule

// File: src/ucre_queue.sv
module ucre_queue (
  input  logic               clk,
  input  logic               rst,
  input  ucre_pkg::q_ctrl_t  ctrl,
  input  ucre_pkg::batch_t   wr_batch,
  output ucre_pkg::batch_t   rd_batch,
  output logic               full,
  output logic               empty
);

  ucre_pkg::batch_t mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (ctrl.push) mem[wr_ptr] <= wr_batch;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (ctrl.push) wr_ptr <= ~wr_ptr;
      if (ctrl.pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, ctrl.push} - {1'b0, ctrl.pop};
    end
  end

  assign rd_batch = mem[rd_ptr];
  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);

  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) full |-> !ctrl.push)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) empty |-> !ctrl.pop)
    else $error("pop from empty queue");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
                                (count == 2'd0 || count == 2'd2) |-> wr_ptr == rd_ptr)
    else $error("queue pointers out of step");

endmodule

// File: src/ucre_back.sv
module ucre_back (
  input  logic              clk,
  input  logic              rst,
  input  ucre_pkg::batch_t  head,
  input  logic              empty,
  output logic              pop,
  input  logic              out_stall,
  output logic              out_valid,
  output ucre_pkg::rec_t    rec,
  output logic              last
);

  logic [2:0] idx;
  logic       load, head_last;

  assign load      = !empty && (!out_valid || !out_stall);
  assign head_last = ({1'b0, idx} == head.cnt - 4'd1);
  assign pop       = load && head_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 3'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= head_last ? 3'd0 : idx + 3'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rec  <= head.recs[idx];
      last <= head_last;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
                                !empty |-> {1'b0, idx} < head.cnt)
    else $error("record index beyond batch");
  a_idx_wrap: assert property (@(posedge clk) disable iff (rst) pop |=> idx == 3'd0)
    else $error("index not rewound after batch");

endmodule

// File: src/usb_ep0_control_request_engine_unit.sv
// USB device EP0 control request engine. Each accepted event is classified in
// the cycle it is taken; its action records (up to eight, "last" on the final
// one, none for a connect) go into a two-batch queue and leave one record per
// cycle while out_stall is low through the output register, so an event takes
// one output slot per record. The output side sets the sustained rate. in_stall
// rises only while both queue slots are taken.
module usb_ep0_control_request_engine_unit #(
  parameter int CONTROL_BUFFER_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [63:0] setup_packet,
  input  logic [7:0]  endpoint,
  input  logic        transfer_error,
  input  logic [15:0] transfer_bytes,
  input  logic [1:0]  link_speed,
  input  logic        function_ok,
  input  logic        endpoints_ok,
  input  logic [15:0] descriptor_length,
  input  logic        submit_ok,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  action,
  output logic [7:0]  target_endpoint,
  output logic        action_flag,
  output logic [15:0] transfer_length,
  output logic [1:0]  data_source,
  output logic [15:0] payload,
  output logic [1:0]  device_state_out,
  output logic        last
);

  ucre_pkg::batch_t  fr_batch, hd_batch;
  ucre_pkg::q_ctrl_t qc;
  ucre_pkg::rec_t    rec;
  logic accept, has_recs, q_full, q_empty, pop;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign qc.push  = accept && has_recs;
  assign qc.pop   = pop;

  ucre_front #(.CONTROL_BUFFER_BYTES(CONTROL_BUFFER_BYTES)) u_front (
    .clk, .rst, .cfg_we, .cfg_wdata, .accept,
    .opcode, .setup_packet, .endpoint, .transfer_error, .transfer_bytes,
    .link_speed, .function_ok, .endpoints_ok, .descriptor_length, .submit_ok,
    .has_recs, .batch(fr_batch)
  );

  ucre_queue u_queue (
    .clk, .rst, .ctrl(qc), .wr_batch(fr_batch), .rd_batch(hd_batch),
    .full(q_full), .empty(q_empty)
  );

  ucre_back u_back (
    .clk, .rst, .head(hd_batch), .empty(q_empty), .pop,
    .out_stall, .out_valid, .rec, .last
  );

  assign action           = rec.action;
  assign target_endpoint  = rec.target_endpoint;
  assign action_flag      = rec.action_flag;
  assign transfer_length  = rec.transfer_length;
  assign data_source      = rec.data_source;
  assign payload          = rec.payload;
  assign device_state_out = rec.device_state_out;

endmodule

// File: tb/tb_usb_ep0_control_request_engine_unit.sv
`timescale 1ns / 100ps
module tb_usb_ep0_control_request_engine_unit;

  localparam int CTRL_BUF = 64;

  typedef struct {
    ucre_pkg::opcode_t op;
    logic [63:0] setup;
    logic [7:0]  ep;
    logic        err;
    logic [15:0] nbytes;
    logic [1:0]  speed;
    logic        fn_ok;
    logic        eps_ok;
    logic [15:0] desc_len;
    logic        sub_ok;
  } event_t;

  typedef struct {
    ucre_pkg::action_t act;
    logic [7:0]  tep;
    logic        flag;
    logic [15:0] len;
    logic [1:0]  src;
    logic [15:0] pay;
    logic [1:0]  dstate;
    logic        lst;
  } action_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] opcode = 2'd0;
  logic [63:0] setup_packet = 64'd0;
  logic [7:0] endpoint = 8'd0;
  logic transfer_error = 1'b0;
  logic [15:0] transfer_bytes = 16'd0;
  logic [1:0] link_speed = 2'd0;
  logic function_ok = 1'b0;
  logic endpoints_ok = 1'b0;
  logic [15:0] descriptor_length = 16'd0;
  logic submit_ok = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] action;
  logic [7:0] target_endpoint;
  logic action_flag;
  logic [15:0] transfer_length;
  logic [1:0] data_source;
  logic [15:0] payload;
  logic [1:0] device_state_out;
  logic last;

  usb_ep0_control_request_engine_unit #(.CONTROL_BUFFER_BYTES(CTRL_BUF)) i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
    .setup_packet(setup_packet), .endpoint(endpoint), .transfer_error(transfer_error),
    .transfer_bytes(transfer_bytes), .link_speed(link_speed), .function_ok(function_ok),
    .endpoints_ok(endpoints_ok), .descriptor_length(descriptor_length),
    .submit_ok(submit_ok), .out_valid(out_valid), .out_stall(out_stall),
    .action(action), .target_endpoint(target_endpoint), .action_flag(action_flag),
    .transfer_length(transfer_length), .data_source(data_source), .payload(payload),
    .device_state_out(device_state_out), .last(last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [7:0]           bulk_ep;
  ucre_pkg::dev_state_t dev_st;
  logic                 cur_cfg;
  ucre_pkg::stage_t     stage;
  logic [1:0]           spd;
  logic                 cur_sub_ok;
  action_rec_t batch[$];

  event_t      pending_events[$];
  action_rec_t expected_actions[$];
  int errors = 0;
  int n_sent = 0;
  int n_seen = 0;
  bit in_quiet = 1'b0;
  bit hold_rx = 1'b0;
  bit drained_hold = 1'b0;

  task automatic push_act(ucre_pkg::action_t a, logic [7:0] e, logic f, logic [15:0] l,
                          logic [1:0] s, logic [15:0] p);
    action_rec_t r;
    r.act = a; r.tep = e; r.flag = f; r.len = l; r.src = s; r.pay = p;
    r.dstate = dev_st; r.lst = 1'b0;
    if (batch.size() < ucre_pkg::MAX_RECS) batch.push_back(r);
  endtask

  task automatic stall_ep0();
    push_act(ucre_pkg::ACT_STALL, 8'h00, 1'b1, 16'd0, ucre_pkg::SRC_CTRL, 16'd0);
  endtask

  task automatic ep0_submit(ucre_pkg::action_t a, ucre_pkg::stage_t s, logic [15:0] l,
                            logic [1:0] src, logic [15:0] p);
    stage = s;
    push_act(a, 8'h00, 1'b0, l, src, p);
    if (!cur_sub_ok) begin
      stage = ucre_pkg::STG_IDLE;
      stall_ep0();
    end
  endtask

  task automatic func_cfg(logic on);
    push_act(ucre_pkg::ACT_FUNC_CFG, 8'h00, on, 16'd0, ucre_pkg::SRC_CTRL, {14'd0, spd});
  endtask

  task automatic standard_req(event_t ev, logic [7:0] bm, logic [7:0] req,
                              logic [15:0] wv, logic [15:0] wi, logic [15:0] wl);
    logic [15:0] dl;
    case (req)
      ucre_pkg::REQ_GET_STATUS: begin
        if (bm[4:0] > 5'd2) stall_ep0();
        else ep0_submit(ucre_pkg::ACT_DATA_IN, ucre_pkg::STG_DIN, 16'd2,
                        ucre_pkg::SRC_CTRL, 16'd0);
      end
      ucre_pkg::REQ_CLEAR_FEATURE, ucre_pkg::REQ_SET_FEATURE: begin
        if (bm != 8'h02 || wv != 16'd0) stall_ep0();
        else begin
          push_act(ucre_pkg::ACT_STALL, wi[7:0], req == ucre_pkg::REQ_SET_FEATURE, 16'd0,
                   ucre_pkg::SRC_CTRL, 16'd0);
          ep0_submit(ucre_pkg::ACT_STATUS_IN, ucre_pkg::STG_SIN, 16'd0,
                     ucre_pkg::SRC_CTRL, 16'd0);
        end
      end
      ucre_pkg::REQ_SET_ADDRESS: begin
        if (bm != 8'h00 || wv > 16'd127 || wi != 16'd0 || wl != 16'd0) stall_ep0();
        else begin
          dev_st = ucre_pkg::DEV_ADDRESSED;
          push_act(ucre_pkg::ACT_SET_ADDR, 8'h00, 1'b0, 16'd0, ucre_pkg::SRC_CTRL, wv);
          ep0_submit(ucre_pkg::ACT_STATUS_IN, ucre_pkg::STG_SIN, 16'd0,
                     ucre_pkg::SRC_CTRL, 16'd0);
        end
      end
      ucre_pkg::REQ_GET_DESC: begin
        dl = ev.desc_len;
        if (dl == 16'd0) stall_ep0();
        else begin
          if (dl > wl) dl = wl;
          ep0_submit(ucre_pkg::ACT_DATA_IN, ucre_pkg::STG_DIN, dl, ucre_pkg::SRC_DESC, 16'd0);
        end
      end
      ucre_pkg::REQ_SET_CONFIG: begin
        if (bm != 8'h00 || wv > 16'd1 || wi != 16'd0 || wl != 16'd0) stall_ep0();
        else begin
          if (wv[0] && dev_st == ucre_pkg::DEV_CONFIGURED) begin
            push_act(ucre_pkg::ACT_CLOSE_EPS, 8'h00, 1'b0, 16'd0, ucre_pkg::SRC_CTRL, 16'd0);
            func_cfg(1'b0);
            dev_st = ucre_pkg::DEV_ADDRESSED;
          end
          cur_cfg = wv[0];
          if (wv[0]) begin
            func_cfg(1'b1);
            if (!ev.fn_ok) begin
              cur_cfg = 1'b0; dev_st = ucre_pkg::DEV_ADDRESSED; stall_ep0(); return;
            end
            push_act(ucre_pkg::ACT_OPEN_EPS, 8'h00, 1'b0, 16'd0, ucre_pkg::SRC_CTRL, 16'd0);
            if (!ev.eps_ok) begin
              cur_cfg = 1'b0; dev_st = ucre_pkg::DEV_ADDRESSED;
              func_cfg(1'b0); stall_ep0(); return;
            end
            dev_st = ucre_pkg::DEV_CONFIGURED;
            push_act(ucre_pkg::ACT_NOTIFY_CFG, 8'h00, 1'b0, 16'd0, ucre_pkg::SRC_CTRL, 16'd0);
          end else begin
            dev_st = ucre_pkg::DEV_ADDRESSED;
            push_act(ucre_pkg::ACT_CLOSE_EPS, 8'h00, 1'b0, 16'd0, ucre_pkg::SRC_CTRL, 16'd0);
            func_cfg(1'b0);
          end
          ep0_submit(ucre_pkg::ACT_STATUS_IN, ucre_pkg::STG_SIN, 16'd0,
                     ucre_pkg::SRC_CTRL, 16'd0);
        end
      end
      ucre_pkg::REQ_GET_CONFIG:
        ep0_submit(ucre_pkg::ACT_DATA_IN, ucre_pkg::STG_DIN, 16'd1, ucre_pkg::SRC_CTRL,
                   {15'd0, cur_cfg});
      ucre_pkg::REQ_GET_IFACE:
        ep0_submit(ucre_pkg::ACT_DATA_IN, ucre_pkg::STG_DIN, 16'd1, ucre_pkg::SRC_CTRL,
                   16'd0);
      ucre_pkg::REQ_SET_IFACE: begin
        if (wv == 16'd0) ep0_submit(ucre_pkg::ACT_STATUS_IN, ucre_pkg::STG_SIN, 16'd0,
                                    ucre_pkg::SRC_CTRL, 16'd0);
        else stall_ep0();
      end
      default: stall_ep0();
    endcase
  endtask

  task automatic class_req(event_t ev, logic [7:0] bm, logic [15:0] wl);
    logic [15:0] l;
    l = (wl > CTRL_BUF) ? 16'(CTRL_BUF) : wl;
    push_act(ucre_pkg::ACT_FWD_CLASS, 8'h00, 1'b0, l, ucre_pkg::SRC_CLASS, 16'd0);
    if (!ev.fn_ok) stall_ep0();
    else if (bm[7]) ep0_submit(ucre_pkg::ACT_DATA_IN, ucre_pkg::STG_DIN, l,
                               ucre_pkg::SRC_CLASS, 16'd0);
    else if (l > 0) ep0_submit(ucre_pkg::ACT_DATA_OUT, ucre_pkg::STG_DOUT, l,
                               ucre_pkg::SRC_CLASS, 16'd0);
    else ep0_submit(ucre_pkg::ACT_STATUS_IN, ucre_pkg::STG_SIN, 16'd0,
                    ucre_pkg::SRC_CTRL, 16'd0);
  endtask

  task automatic xfer_done(event_t ev);
    if (ev.ep == 8'h00 || ev.ep == 8'h80) begin
      case (stage)
        ucre_pkg::STG_DIN: begin
          if (ev.err) begin stage = ucre_pkg::STG_IDLE; stall_ep0(); end
          else ep0_submit(ucre_pkg::ACT_STATUS_OUT, ucre_pkg::STG_SOUT, 16'd0,
                          ucre_pkg::SRC_CTRL, 16'd0);
        end
        ucre_pkg::STG_DOUT: begin
          if (ev.err || ev.nbytes == 0) begin
            stage = ucre_pkg::STG_IDLE; stall_ep0();
          end else begin
            push_act(ucre_pkg::ACT_CTRL_OUT, 8'h00, 1'b0, ev.nbytes, ucre_pkg::SRC_CTRL,
                     16'd0);
            if (!ev.fn_ok) begin stage = ucre_pkg::STG_IDLE; stall_ep0(); end
            else ep0_submit(ucre_pkg::ACT_STATUS_IN, ucre_pkg::STG_SIN, 16'd0,
                            ucre_pkg::SRC_CTRL, 16'd0);
          end
        end
        ucre_pkg::STG_SIN, ucre_pkg::STG_SOUT: begin
          stage = ucre_pkg::STG_IDLE;
          if (ev.err) stall_ep0();
        end
        default: ;
      endcase
    end else begin
      push_act(ucre_pkg::ACT_EP_DONE, ev.ep, ev.err, ev.nbytes, ucre_pkg::SRC_CTRL, 16'd0);
      if (ev.err) begin
        if (!ev.ep[7]) push_act(ucre_pkg::ACT_RECOVER_RX, ev.ep, 1'b0, 16'd0,
                                ucre_pkg::SRC_CTRL, 16'd0);
        else push_act(ucre_pkg::ACT_REOPEN_IN, ev.ep, 1'b0, 16'd0, ucre_pkg::SRC_CTRL, 16'd0);
      end else if (ev.ep == bulk_ep && dev_st == ucre_pkg::DEV_CONFIGURED) begin
        push_act(ucre_pkg::ACT_REQUEUE_RX, ev.ep, 1'b0, 16'd0, ucre_pkg::SRC_CTRL, 16'd0);
        if (!cur_sub_ok) push_act(ucre_pkg::ACT_RECOVER_RX, ev.ep, 1'b0, 16'd0,
                                  ucre_pkg::SRC_CTRL, 16'd0);
      end
    end
  endtask

  task automatic predict_event(event_t ev);
    batch.delete();
    cur_sub_ok = ev.sub_ok;
    case (ev.op)
      ucre_pkg::OP_RESET: begin
        dev_st = ucre_pkg::DEV_DEFAULT; cur_cfg = 1'b0; stage = ucre_pkg::STG_IDLE;
        push_act(ucre_pkg::ACT_CLOSE_EPS, 8'h00, 1'b0, 16'd0, ucre_pkg::SRC_CTRL, 16'd0);
        func_cfg(1'b0);
      end
      ucre_pkg::OP_SETUP: begin
        stage = ucre_pkg::STG_IDLE;
        if (ev.setup[6:5] == ucre_pkg::TYPE_STANDARD)
          standard_req(ev, ev.setup[7:0], ev.setup[15:8], ev.setup[31:16],
                       ev.setup[47:32], ev.setup[63:48]);
        else if (ev.setup[6:5] == ucre_pkg::TYPE_CLASS)
          class_req(ev, ev.setup[7:0], ev.setup[63:48]);
        else stall_ep0();
      end
      ucre_pkg::OP_XFER: xfer_done(ev);
      default: spd = ev.speed;
    endcase
    if (batch.size() > 0) batch[batch.size()-1].lst = 1'b1;
    foreach (batch[i]) expected_actions.push_back(batch[i]);
  endtask

  // driver
  int gap_in = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        n_sent <= n_sent + 1;
        if (!in_quiet && $urandom_range(0, 3) == 0) gap_in = $urandom_range(1, 9);
      end
      if (!in_valid || !in_stall) begin
        if (gap_in > 0) begin
          gap_in--;
          in_valid <= 1'b0;
        end else if (pending_events.size() > 0) begin
          event_t ev;
          ev = pending_events.pop_front();
          predict_event(ev);
          in_valid <= 1'b1;
          opcode <= ev.op; setup_packet <= ev.setup; endpoint <= ev.ep;
          transfer_error <= ev.err; transfer_bytes <= ev.nbytes; link_speed <= ev.speed;
          function_ok <= ev.fn_ok; endpoints_ok <= ev.eps_ok;
          descriptor_length <= ev.desc_len; submit_ok <= ev.sub_ok;
        end else in_valid <= 1'b0;
      end
    end
  end

  // receiver stall and checker
  int gap_out = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        action_rec_t e;
        n_seen <= n_seen + 1;
        if (expected_actions.size() == 0) begin
          $error("unexpected action record %0d", action);
          errors++;
        end else begin
          e = expected_actions.pop_front();
          if (action !== e.act) begin
            $error("action exp %0d got %0d", e.act, action); errors++;
          end
          if (target_endpoint !== e.tep) begin
            $error("target_endpoint exp %0h got %0h", e.tep, target_endpoint); errors++;
          end
          if (action_flag !== e.flag) begin
            $error("action_flag exp %0d got %0d", e.flag, action_flag); errors++;
          end
          if (transfer_length !== e.len) begin
            $error("transfer_length exp %0d got %0d", e.len, transfer_length); errors++;
          end
          if (data_source !== e.src) begin
            $error("data_source exp %0d got %0d", e.src, data_source); errors++;
          end
          if (payload !== e.pay) begin
            $error("payload exp %0h got %0h", e.pay, payload); errors++;
          end
          if (device_state_out !== e.dstate) begin
            $error("device_state_out exp %0d got %0d", e.dstate, device_state_out); errors++;
          end
          if (last !== e.lst) begin
            $error("last exp %0d got %0d", e.lst, last); errors++;
          end
        end
      end
      if (hold_rx) out_stall <= 1'b1;
      else if (gap_out > 0) begin
        gap_out--;
        out_stall <= 1'b1;
      end else if (!in_quiet && $urandom_range(0, 4) == 0) begin
        gap_out = $urandom_range(1, 9);
        out_stall <= 1'b1;
      end else out_stall <= 1'b0;
    end
  end

  function automatic logic [63:0] mk_setup(logic [7:0] bm, logic [7:0] req,
                                           logic [15:0] wv, logic [15:0] wi, logic [15:0] wl);
    return {wl, wi, wv, req, bm};
  endfunction

  function automatic event_t base_event(ucre_pkg::opcode_t op);
    event_t ev;
    ev.op = op; ev.setup = '0; ev.ep = '0; ev.err = 1'b0; ev.nbytes = '0;
    ev.speed = '0; ev.fn_ok = 1'b1; ev.eps_ok = 1'b1; ev.desc_len = 16'd18;
    ev.sub_ok = 1'b1;
    return ev;
  endfunction

  function automatic event_t rand_event();
    event_t ev;
    ev.op = ucre_pkg::opcode_t'($urandom_range(0, 3));
    ev.setup = {$urandom(), $urandom()};
    ev.ep = 8'($urandom());
    ev.err = 1'($urandom());
    ev.nbytes = 16'($urandom());
    ev.speed = 2'($urandom());
    ev.fn_ok = 1'($urandom()); ev.eps_ok = 1'($urandom());
    ev.desc_len = 16'($urandom()); ev.sub_ok = 1'($urandom());
    return ev;
  endfunction

  // mostly well-formed requests and stage completions with random answers
  function automatic event_t shaped_event(logic [7:0] bulk);
    event_t ev;
    logic [7:0] reqs[9];
    int k;
    reqs = '{ucre_pkg::REQ_GET_STATUS, ucre_pkg::REQ_CLEAR_FEATURE, ucre_pkg::REQ_SET_FEATURE,
             ucre_pkg::REQ_SET_ADDRESS, ucre_pkg::REQ_GET_DESC, ucre_pkg::REQ_GET_CONFIG,
             ucre_pkg::REQ_SET_CONFIG, ucre_pkg::REQ_GET_IFACE, ucre_pkg::REQ_SET_IFACE};
    ev = base_event(ucre_pkg::OP_SETUP);
    ev.fn_ok = ($urandom_range(0, 7) != 0);
    ev.eps_ok = ($urandom_range(0, 7) != 0);
    ev.sub_ok = ($urandom_range(0, 7) != 0);
    ev.desc_len = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 300));
    k = $urandom_range(0, 15);
    if (k < 7) begin
      logic [7:0] rq;
      logic [7:0] bm;
      rq = reqs[$urandom_range(0, 8)];
      bm = (rq == ucre_pkg::REQ_CLEAR_FEATURE || rq == ucre_pkg::REQ_SET_FEATURE) ?
           8'h02 : 8'h00;
      if (rq == ucre_pkg::REQ_GET_STATUS) bm = 8'h80 | 8'($urandom_range(0, 3));
      ev.setup = mk_setup(bm, rq,
        (rq == ucre_pkg::REQ_SET_CONFIG) ? 16'($urandom_range(0, 1)) :
        (rq == ucre_pkg::REQ_SET_ADDRESS) ? 16'($urandom_range(0, 127)) :
        (rq == ucre_pkg::REQ_GET_DESC) ? 16'h0100 : 16'd0,
        (rq == ucre_pkg::REQ_CLEAR_FEATURE || rq == ucre_pkg::REQ_SET_FEATURE) ?
          16'($urandom_range(0, 255)) : 16'd0,
        (rq == ucre_pkg::REQ_GET_DESC) ? 16'($urandom_range(0, 255)) : 16'd0);
    end else if (k < 9) begin
      ev.setup = mk_setup({$urandom_range(0, 1) == 1, 7'h21}, 8'($urandom()),
                          16'($urandom()), 16'd0, 16'($urandom_range(0, 100)));
    end else if (k < 13) begin
      ev.op = ucre_pkg::OP_XFER;
      ev.ep = $urandom_range(0, 1) ? 8'h80 : 8'h00;
      ev.err = ($urandom_range(0, 7) == 0);
      ev.nbytes = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 64));
    end else if (k < 15) begin
      ev.op = ucre_pkg::OP_XFER;
      ev.ep = $urandom_range(0, 1) ? bulk : 8'($urandom());
      ev.err = ($urandom_range(0, 5) == 0);
      ev.nbytes = 16'($urandom());
    end else ev = rand_event();
    return ev;
  endfunction

  task automatic wait_drained();
    while (pending_events.size() > 0 || in_valid || expected_actions.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_bulk(logic [7:0] v);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    bulk_ep = v;
  endtask

  initial begin
    event_t ev;
    logic [7:0] bulk_vals[4];
    bulk_ep = 8'd1; dev_st = ucre_pkg::DEV_DEFAULT; cur_cfg = 1'b0;
    stage = ucre_pkg::STG_IDLE; spd = 2'd0;
    bulk_vals = '{8'h00, 8'hFF, 8'h02, 8'h81};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed enumeration, each standard request but GET_STATUS, class requests, failures and completions
    ev = base_event(ucre_pkg::OP_CONNECT); ev.speed = 2'd3; pending_events.push_back(ev);
    ev = base_event(ucre_pkg::OP_SETUP);
    ev.setup = mk_setup(8'h80, ucre_pkg::REQ_GET_DESC, 16'h0100, 16'd0, 16'd64);
    pending_events.push_back(ev);
    ev = base_event(ucre_pkg::OP_XFER); ev.ep = 8'h80; pending_events.push_back(ev);
    ev = base_event(ucre_pkg::OP_XFER); ev.ep = 8'h00; ev.err = 1'b1;
    pending_events.push_back(ev);
    ev = base_event(ucre_pkg::OP_SETUP);
    ev.setup = mk_setup(8'h00, ucre_pkg::REQ_SET_ADDRESS, 16'd127, 16'd0, 16'd0);
    pending_events.push_back(ev);
    ev = base_event(ucre_pkg::OP_SETUP);
    ev.setup = mk_setup(8'h00, ucre_pkg::REQ_SET_CONFIG, 16'd1, 16'd0, 16'd0);
    pending_events.push_back(ev);
    ev = base_event(ucre_pkg::OP_SETUP);
    ev.setup = mk_setup(8'h00, ucre_pkg::REQ_SET_CONFIG, 16'd1, 16'd0, 16'd0);
    ev.eps_ok = 1'b0; pending_events.push_back(ev);
    ev = base_event(ucre_pkg::OP_SETUP);
    ev.setup = mk_setup(8'h00, ucre_pkg::REQ_SET_CONFIG, 16'd1, 16'd0, 16'd0);
    ev.fn_ok = 1'b0; pending_events.push_back(ev);
    ev = base_event(ucre_pkg::OP_SETUP);
    ev.setup = mk_setup(8'h00, ucre_pkg::REQ_SET_CONFIG, 16'd1, 16'd0, 16'd0);
    pending_events.push_back(ev);
    ev = base_event(ucre_pkg::OP_XFER); ev.ep = 8'h01; ev.nbytes = 16'hFFFF;
    ev.sub_ok = 1'b0; pending_events.push_back(ev);
    ev = base_event(ucre_pkg::OP_XFER); ev.ep = 8'h82; ev.err = 1'b1;
    pending_events.push_back(ev);
    ev = base_event(ucre_pkg::OP_XFER); ev.ep = 8'h7F; ev.err = 1'b1;
    pending_events.push_back(ev);
    ev = base_event(ucre_pkg::OP_SETUP);
    ev.setup = mk_setup(8'h80, ucre_pkg::REQ_GET_CONFIG, 16'd0, 16'd0, 16'd1);
    pending_events.push_back(ev);
    ev = base_event(ucre_pkg::OP_SETUP);
    ev.setup = mk_setup(8'h02, ucre_pkg::REQ_SET_FEATURE, 16'd0, 16'h81, 16'd0);
    ev.sub_ok = 1'b0; pending_events.push_back(ev);
    ev = base_event(ucre_pkg::OP_SETUP);
    ev.setup = mk_setup(8'h02, ucre_pkg::REQ_CLEAR_FEATURE, 16'd0, 16'hFF, 16'd0);
    pending_events.push_back(ev);
    ev = base_event(ucre_pkg::OP_SETUP);
    ev.setup = mk_setup(8'h21, 8'h09, 16'd0, 16'd0, 16'hFFFF);
    pending_events.push_back(ev);
    ev = base_event(ucre_pkg::OP_XFER); ev.nbytes = 16'd8; pending_events.push_back(ev);
    ev = base_event(ucre_pkg::OP_XFER); pending_events.push_back(ev);
    ev = base_event(ucre_pkg::OP_SETUP);
    ev.setup = mk_setup(8'hA1, 8'h01, 16'd0, 16'd0, 16'd7);
    pending_events.push_back(ev);
    ev = base_event(ucre_pkg::OP_SETUP);
    ev.setup = mk_setup(8'h81, ucre_pkg::REQ_GET_IFACE, 16'd0, 16'd0, 16'd1);
    pending_events.push_back(ev);
    ev = base_event(ucre_pkg::OP_SETUP);
    ev.setup = mk_setup(8'h01, ucre_pkg::REQ_SET_IFACE, 16'd1, 16'd0, 16'd0);
    pending_events.push_back(ev);
    ev = base_event(ucre_pkg::OP_SETUP);
    ev.setup = mk_setup(8'hC0, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    pending_events.push_back(ev);
    ev = base_event(ucre_pkg::OP_SETUP);
    ev.setup = mk_setup(8'h00, ucre_pkg::REQ_SET_CONFIG, 16'd0, 16'd0, 16'd0);
    pending_events.push_back(ev);
    ev = base_event(ucre_pkg::OP_SETUP);
    ev.setup = mk_setup(8'h80, ucre_pkg::REQ_GET_DESC, 16'h0200, 16'd0, 16'd9);
    ev.desc_len = 16'd0; pending_events.push_back(ev);
    ev = base_event(ucre_pkg::OP_RESET); pending_events.push_back(ev);
    wait_drained();

    // random phases, one per register setting
    foreach (bulk_vals[p]) begin
      write_bulk(bulk_vals[p]);
      ev = base_event(ucre_pkg::OP_SETUP);
      ev.setup = mk_setup(8'h00, ucre_pkg::REQ_SET_CONFIG, 16'd1, 16'd0, 16'd0);
      pending_events.push_back(ev);
      for (int i = 0; i < 28; i++) pending_events.push_back(shaped_event(bulk_vals[p]));
      if (p == 1) begin
        // hold the receiver so the queue fills and the input stalls
        wait (pending_events.size() < 30);
        hold_rx = 1'b1;
        repeat (120) @(posedge clk);
        hold_rx = 1'b0;
      end
      wait_drained();
    end

    in_quiet = 1'b1;
    for (int i = 0; i < 20; i++) pending_events.push_back(shaped_event(bulk_ep));
    wait_drained();
    $display("sent %0d events over 4 bulk endpoint settings, checked %0d action records",
             n_sent, n_seen);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: files.f
src/ucre_pkg.sv
src/ucre_front.sv
src/ucre_queue.sv
src/ucre_back.sv
src/usb_ep0_control_request_engine_unit.sv
tb/tb_usb_ep0_control_request_engine_unit.sv
